// ===== sv/mcfd_pkg.sv =====
// ----------------------------------------------------------------------------
// mcfd_pkg: shared definitions for the motor command frame decoder
// Widths, frame codes, lamp codes, sequencer states and the divider link.
// ----------------------------------------------------------------------------
package mcfd_pkg;

    localparam int DUTY_BITS  = 24;
    localparam int BYTE_W     = 8;
    localparam int TIMEOUT_W  = 16;
    localparam int CFG_W      = 24;
    localparam int CFG_IDX_W  = 1;
    localparam int SLOT_W     = 2;
    localparam int FRAME_LEN  = 4;
    localparam int PROD_W     = DUTY_BITS + BYTE_W;
    localparam int DIV_CNT_W  = $clog2(PROD_W);

    localparam logic [TIMEOUT_W-1:0] TIMEOUT_RESET = TIMEOUT_W'(30000);
    localparam logic [DUTY_BITS-1:0] PERIOD_RESET  = DUTY_BITS'(4080000);

    // Register indexes on the write port
    localparam logic [CFG_IDX_W-1:0] REG_PWM_PERIOD    = 1'b0;
    localparam logic [CFG_IDX_W-1:0] REG_FRAME_TIMEOUT = 1'b1;

    // Frame command codes
    localparam logic [BYTE_W-1:0] CMD_FWD   = 8'hF1;
    localparam logic [BYTE_W-1:0] CMD_REV   = 8'hF2;
    localparam logic [BYTE_W-1:0] CMD_BRAKE = 8'hF3;
    localparam logic [BYTE_W-1:0] CMD_NOP   = 8'hF4;
    localparam logic [BYTE_W-1:0] CMD_OFF   = 8'hF5;

    localparam logic [BYTE_W-1:0] ANGLE_CENTRE = 8'd150;
    localparam logic [BYTE_W-1:0] SPEED_FULL   = 8'd255;
    localparam logic [BYTE_W-1:0] STEER_SCALE  = 8'd10;
    localparam int                HORN_BIT     = 5;

    localparam logic [SLOT_W-1:0] SLOT_CMD  = 2'd0;
    localparam logic [SLOT_W-1:0] SLOT_LAST = 2'd3;

    // Drive lamp codes
    localparam logic [1:0] LED_OFF   = 2'd0;
    localparam logic [1:0] LED_FWD   = 2'd1;
    localparam logic [1:0] LED_REV   = 2'd2;
    localparam logic [1:0] LED_BRAKE = 2'd3;

    // Steering indicator codes
    localparam logic [1:0] IND_CENTRE = 2'd0;
    localparam logic [1:0] IND_LEFT   = 2'd1;
    localparam logic [1:0] IND_RIGHT  = 2'd2;
    localparam logic [1:0] IND_DARK   = 2'd3;

    typedef enum logic [3:0] {
        S_IDLE = 4'b0001,
        S_LOAD = 4'b0010,
        S_DIV  = 4'b0100,
        S_OUT  = 4'b1000
    } state_t;

    typedef struct packed {
        logic              start;
        logic [PROD_W-1:0] dividend;
        logic [BYTE_W-1:0] divisor;
    } div_req_t;

    typedef struct packed {
        logic              done;
        logic [PROD_W-1:0] quotient;
    } div_rsp_t;

endpackage

// ===== sv/mcfd_in_if.sv =====
// ----------------------------------------------------------------------------
// mcfd_in_if: input word channel
// One received byte or one time tick per word.
// ----------------------------------------------------------------------------
interface mcfd_in_if;
    logic                       valid;
    logic                       ready;
    logic                       operation;
    logic [mcfd_pkg::BYTE_W-1:0] rx_byte;

    modport source (output valid, output operation, output rx_byte, input ready);
    modport sink   (input valid, input operation, input rx_byte, output ready);
endinterface

// ===== sv/mcfd_out_if.sv =====
// ----------------------------------------------------------------------------
// mcfd_out_if: result word channel
// Drive, steering and horn actions from one frame or one timeout.
// ----------------------------------------------------------------------------
interface mcfd_out_if;
    logic                           valid;
    logic                           ready;
    logic                           all_off;
    logic                           drive_update;
    logic                           forward_pin;
    logic                           reverse_pin;
    logic [mcfd_pkg::DUTY_BITS-1:0] drive_duty;
    logic [1:0]                     drive_led;
    logic                           steer_update;
    logic [mcfd_pkg::DUTY_BITS-1:0] steer_duty;
    logic [1:0]                     steer_indicator;
    logic                           horn_update;
    logic                           horn_on;

    modport source (
        output valid, output all_off, output drive_update, output forward_pin,
        output reverse_pin, output drive_duty, output drive_led, output steer_update,
        output steer_duty, output steer_indicator, output horn_update, output horn_on,
        input ready
    );
    modport sink (
        input valid, input all_off, input drive_update, input forward_pin,
        input reverse_pin, input drive_duty, input drive_led, input steer_update,
        input steer_duty, input steer_indicator, input horn_update, input horn_on,
        output ready
    );
endinterface

// ===== sv/mcfd_div.sv =====
// ----------------------------------------------------------------------------
// mcfd_div: shared restoring divider
// Product by 8-bit divisor, one quotient bit per cycle, done pulse at end.
// ----------------------------------------------------------------------------
module mcfd_div (
    input  logic               clk,
    input  logic               rst_n,
    input  mcfd_pkg::div_req_t req,
    output mcfd_pkg::div_rsp_t rsp
);
    import mcfd_pkg::*;

    logic                 busy_reg;
    logic                 done_reg;
    logic [DIV_CNT_W-1:0] cnt_reg;
    logic [PROD_W-1:0]    quo_reg;
    logic [BYTE_W-1:0]    rem_reg;
    logic [BYTE_W-1:0]    dvs_reg;

    logic [BYTE_W:0]      rem_shift;
    logic [BYTE_W:0]      rem_sub;
    logic                 fits;

    always_comb
    begin
        rem_shift = {rem_reg, quo_reg[PROD_W-1]};
        rem_sub   = rem_shift - {1'b0, dvs_reg};
        fits      = rem_shift >= {1'b0, dvs_reg};
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            done_reg <= busy_reg && (cnt_reg == '0);
            if (req.start)
            begin
                busy_reg <= 1'b1;
                cnt_reg  <= DIV_CNT_W'(PROD_W - 1);
            end
            else if (busy_reg)
            begin
                if (cnt_reg == '0)
                    busy_reg <= 1'b0;
                cnt_reg <= cnt_reg - 1'b1;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (req.start)
        begin
            quo_reg <= req.dividend;
            rem_reg <= '0;
            dvs_reg <= req.divisor;
        end
        else if (busy_reg)
        begin
            quo_reg <= {quo_reg[PROD_W-2:0], fits};
            rem_reg <= fits ? rem_sub[BYTE_W-1:0] : rem_shift[BYTE_W-1:0];
        end
    end

    assign rsp.done     = done_reg;
    assign rsp.quotient = quo_reg;

endmodule

// ===== sv/motor_command_frame_decoder.sv =====
// ----------------------------------------------------------------------------
// motor_command_frame_decoder: serial motor command frame decoder
// Gathers 4-byte frames, applies changed parts, times out to all-off.
// ----------------------------------------------------------------------------
//  channel   dir  handshake          word
//  item      in   valid/ready        operation, rx_byte
//  result    out  valid/ready        all_off .. horn_on (11 fields)
//  cfg       in   cfg_we, no wait    cfg_index, cfg_data
//
//  A tick or byte with no action is accepted and ready stays high.
//  A result needs up to two divisions in the shared divider
//  (drive duty and steering duty) before it is offered.
//  item.ready is low from the accepting word until the result is taken.
//  Reset (rst_n, async) empties the frame and restores the register defaults.
// ----------------------------------------------------------------------------
module motor_command_frame_decoder (
    input  logic                              clk,
    input  logic                              rst_n,
    mcfd_in_if.sink                           item,
    mcfd_out_if.source                        result,
    input  logic                              cfg_we,
    input  logic [mcfd_pkg::CFG_IDX_W-1:0]    cfg_index,
    input  logic [mcfd_pkg::CFG_W-1:0]        cfg_data
);
    import mcfd_pkg::*;

    state_t                 state_reg, state_next;
    logic [DUTY_BITS-1:0]   period_reg;
    logic [TIMEOUT_W-1:0]   timeout_reg;
    logic [BYTE_W-1:0]      frame_reg [FRAME_LEN];
    logic [BYTE_W-1:0]      prev_reg  [FRAME_LEN];
    logic [SLOT_W-1:0]      slot_reg;
    logic [TIMEOUT_W-1:0]   idle_reg;
    logic                   drive_pend_reg;
    logic                   steer_pend_reg;
    logic [BYTE_W-1:0]      steer_dvs_reg;

    logic                   all_off_reg;
    logic                   drive_upd_reg;
    logic                   fwd_reg;
    logic                   rev_reg;
    logic [DUTY_BITS-1:0]   drive_duty_reg;
    logic [1:0]             drive_led_reg;
    logic                   steer_upd_reg;
    logic [DUTY_BITS-1:0]   steer_duty_reg;
    logic [1:0]             steer_ind_reg;
    logic                   horn_upd_reg;
    logic                   horn_on_reg;

    div_req_t               div_req;
    div_rsp_t               div_rsp;

    logic                   in_acc;
    logic [TIMEOUT_W:0]     idle_inc;
    logic [TIMEOUT_W-1:0]   limit;
    logic                   timed_out;
    logic                   cmd_ok;
    logic                   frame_done;
    logic                   has_result;
    logic                   cmd_chg;
    logic                   drv;
    logic                   shut_any;
    logic                   ang_chg;
    logic                   acc_chg;
    logic                   drive_pend_new;
    logic                   steer_pend_new;
    logic [1:0]             led_new;
    logic [1:0]             ind_new;
    logic [BYTE_W-1:0]      mult;
    logic [DUTY_BITS-1:0]   duty_sat;

    assign in_acc = item.valid && item.ready;

    always_comb
    begin
        idle_inc   = {1'b0, idle_reg} + 1'b1;
        limit      = (timeout_reg == '0) ? TIMEOUT_W'(1) : timeout_reg;
        timed_out  = idle_inc >= {1'b0, limit};
        cmd_ok     = (item.rx_byte >= CMD_FWD) && (item.rx_byte <= CMD_OFF);
        frame_done = !item.operation && (slot_reg == SLOT_LAST);
        has_result = item.operation ? timed_out : frame_done;

        cmd_chg  = (frame_reg[0] != prev_reg[0]) || (frame_reg[1] != prev_reg[1]);
        drv      = frame_done && cmd_chg && (frame_reg[0] <= CMD_BRAKE);
        shut_any = item.operation || (cmd_chg && (frame_reg[0] == CMD_OFF));
        ang_chg  = frame_done && (frame_reg[2] != prev_reg[2]);
        acc_chg  = frame_done && (item.rx_byte != prev_reg[3]);

        drive_pend_new = drv && ((frame_reg[0] == CMD_FWD) || (frame_reg[0] == CMD_REV));
        steer_pend_new = ang_chg ? (frame_reg[2] != '0) : shut_any;

        if (frame_reg[0] == CMD_FWD)
            led_new = LED_FWD;
        else if (frame_reg[0] == CMD_REV)
            led_new = LED_REV;
        else
            led_new = LED_BRAKE;

        if (frame_reg[2] < ANGLE_CENTRE)
            ind_new = IND_LEFT;
        else if (frame_reg[2] > ANGLE_CENTRE)
            ind_new = IND_RIGHT;
        else
            ind_new = IND_CENTRE;
    end

    // Divider operand: period times speed or times ten
    always_comb
    begin
        mult             = drive_pend_reg ? frame_reg[1] : STEER_SCALE;
        div_req.start    = (state_reg == S_LOAD);
        div_req.dividend = PROD_W'(period_reg) * PROD_W'(mult);
        div_req.divisor  = drive_pend_reg ? SPEED_FULL : steer_dvs_reg;
        duty_sat = (div_rsp.quotient > PROD_W'(period_reg)) ? period_reg
                                                             : div_rsp.quotient[DUTY_BITS-1:0];
    end

    mcfd_div u_div (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (div_req),
        .rsp   (div_rsp)
    );

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            S_IDLE:
            begin
                if (in_acc && has_result)
                    state_next = (drive_pend_new || steer_pend_new) ? S_LOAD : S_OUT;
            end
            S_LOAD:
                state_next = S_DIV;
            S_DIV:
            begin
                if (div_rsp.done)
                    state_next = (drive_pend_reg && steer_pend_reg) ? S_LOAD : S_OUT;
            end
            S_OUT:
            begin
                if (result.ready)
                    state_next = S_IDLE;
            end
            default:
                state_next = S_IDLE;
        endcase
    end

    // Control and frame state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= S_IDLE;
            period_reg     <= PERIOD_RESET;
            timeout_reg    <= TIMEOUT_RESET;
            slot_reg       <= SLOT_CMD;
            idle_reg       <= '0;
            drive_pend_reg <= 1'b0;
            steer_pend_reg <= 1'b0;
            for (int i = 0; i < FRAME_LEN; i++)
            begin
                frame_reg[i] <= '0;
                prev_reg[i]  <= '0;
            end
        end
        else
        begin
            state_reg <= state_next;

            if (cfg_we)
            begin
                unique case (cfg_index)
                    REG_PWM_PERIOD:    period_reg  <= cfg_data[DUTY_BITS-1:0];
                    REG_FRAME_TIMEOUT: timeout_reg <= cfg_data[TIMEOUT_W-1:0];
                    default: ;
                endcase
            end

            if (in_acc)
            begin
                drive_pend_reg <= has_result && drive_pend_new;
                steer_pend_reg <= has_result && steer_pend_new;
                if (item.operation)
                begin
                    idle_reg <= timed_out ? '0 : idle_inc[TIMEOUT_W-1:0];
                end
                else
                begin
                    frame_reg[slot_reg] <= item.rx_byte;
                    if ((slot_reg == SLOT_CMD) && !cmd_ok)
                        slot_reg <= SLOT_CMD;
                    else if (slot_reg != SLOT_LAST)
                        slot_reg <= slot_reg + 1'b1;
                    else
                    begin
                        slot_reg    <= SLOT_CMD;
                        idle_reg    <= '0;
                        prev_reg[0] <= frame_reg[0];
                        prev_reg[1] <= frame_reg[1];
                        prev_reg[2] <= frame_reg[2];
                        prev_reg[3] <= item.rx_byte;
                    end
                end
            end
            else if ((state_reg == S_DIV) && div_rsp.done)
            begin
                if (drive_pend_reg)
                    drive_pend_reg <= 1'b0;
                else
                    steer_pend_reg <= 1'b0;
            end
        end
    end

    // Result word
    always_ff @(posedge clk)
    begin
        if (in_acc && has_result)
        begin
            all_off_reg    <= shut_any;
            drive_upd_reg  <= shut_any || drv;
            fwd_reg        <= shut_any || (drv && (frame_reg[0] == CMD_FWD));
            rev_reg        <= shut_any || (drv && (frame_reg[0] == CMD_REV));
            drive_duty_reg <= '0;
            drive_led_reg  <= drv ? led_new : LED_OFF;
            steer_dvs_reg  <= ang_chg ? frame_reg[2] : ANGLE_CENTRE;
            // a changed angle overrides the shut-off steering
            if (ang_chg)
            begin
                steer_upd_reg  <= 1'b1;
                steer_ind_reg  <= ind_new;
                steer_duty_reg <= period_reg;
            end
            else if (shut_any)
            begin
                steer_upd_reg  <= 1'b1;
                steer_ind_reg  <= IND_DARK;
                steer_duty_reg <= '0;
            end
            else
            begin
                steer_upd_reg  <= 1'b0;
                steer_ind_reg  <= IND_CENTRE;
                steer_duty_reg <= '0;
            end
            horn_upd_reg <= acc_chg;
            horn_on_reg  <= acc_chg && item.rx_byte[HORN_BIT];
        end
        else if ((state_reg == S_DIV) && div_rsp.done)
        begin
            if (drive_pend_reg)
                drive_duty_reg <= duty_sat;
            else
                steer_duty_reg <= duty_sat;
        end
    end

    assign item.ready = (state_reg == S_IDLE);

    assign result.valid           = (state_reg == S_OUT);
    assign result.all_off         = all_off_reg;
    assign result.drive_update    = drive_upd_reg;
    assign result.forward_pin     = fwd_reg;
    assign result.reverse_pin     = rev_reg;
    assign result.drive_duty      = drive_duty_reg;
    assign result.drive_led       = drive_led_reg;
    assign result.steer_update    = steer_upd_reg;
    assign result.steer_duty      = steer_duty_reg;
    assign result.steer_indicator = steer_ind_reg;
    assign result.horn_update     = horn_upd_reg;
    assign result.horn_on         = horn_on_reg;

endmodule

// ===== sv/mcfd_checker.sv =====
// ----------------------------------------------------------------------------
// mcfd_checker: port-level checks for the frame decoder
// Watches the item and result channels; bound to the top level.
// ----------------------------------------------------------------------------
module mcfd_checker (
    input logic                           clk,
    input logic                           rst_n,
    input logic                           in_ready,
    input logic                           out_valid,
    input logic                           out_ready,
    input logic                           all_off,
    input logic                           drive_update,
    input logic                           forward_pin,
    input logic                           reverse_pin,
    input logic [mcfd_pkg::DUTY_BITS-1:0] drive_duty,
    input logic [1:0]                     drive_led,
    input logic                           steer_update,
    input logic [mcfd_pkg::DUTY_BITS-1:0] steer_duty,
    input logic [1:0]                     steer_indicator,
    input logic                           horn_update,
    input logic                           horn_on
);
    import mcfd_pkg::*;

    // one word in flight: no new input while a result waits
    a_no_overlap: assert property (@(posedge clk) disable iff (!rst_n)
        !(out_valid && in_ready))
        else $error("input ready while result pending");

    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(drive_duty) && $stable(steer_duty))
        else $error("stalled result word changed");

    a_shutoff: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && all_off |-> drive_update && forward_pin && reverse_pin
                                  && (drive_duty == '0) && (drive_led == LED_OFF)
                                  && steer_update)
        else $error("shut-off word malformed");

    a_quiet_fields: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> (drive_update || (!forward_pin && !reverse_pin
                                        && (drive_duty == '0) && (drive_led == LED_OFF)))
                      && (steer_update || ((steer_duty == '0) && (steer_indicator == IND_CENTRE)))
                      && (horn_update || !horn_on))
        else $error("fields set without update flag");

endmodule

bind motor_command_frame_decoder mcfd_checker u_mcfd_checker (
    .clk             (clk),
    .rst_n           (rst_n),
    .in_ready        (item.ready),
    .out_valid       (result.valid),
    .out_ready       (result.ready),
    .all_off         (result.all_off),
    .drive_update    (result.drive_update),
    .forward_pin     (result.forward_pin),
    .reverse_pin     (result.reverse_pin),
    .drive_duty      (result.drive_duty),
    .drive_led       (result.drive_led),
    .steer_update    (result.steer_update),
    .steer_duty      (result.steer_duty),
    .steer_indicator (result.steer_indicator),
    .horn_update     (result.horn_update),
    .horn_on         (result.horn_on)
);

// ===== sim/tb_motor_command_frame_decoder.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_motor_command_frame_decoder: self-checking bench for the frame decoder
// Streams byte and tick words under random pacing, predicts every drive,
// steering and horn action in a scoreboard and checks each result word
// field by field across several PWM period and frame timeout settings.
// ----------------------------------------------------------------------------
import mcfd_pkg::*;

typedef struct packed {
    logic                 all_off;
    logic                 drive_update;
    logic                 forward_pin;
    logic                 reverse_pin;
    logic [DUTY_BITS-1:0] drive_duty;
    logic [1:0]           drive_led;
    logic                 steer_update;
    logic [DUTY_BITS-1:0] steer_duty;
    logic [1:0]           steer_indicator;
    logic                 horn_update;
    logic                 horn_on;
} action_t;

class frame_action_scoreboard;
    action_t              expected_actions[$];
    logic [BYTE_W-1:0]    frame_buf[FRAME_LEN];
    logic [BYTE_W-1:0]    last_frame[FRAME_LEN];
    logic [SLOT_W-1:0]    slot;
    logic [TIMEOUT_W-1:0] idle_ticks;
    longint unsigned      period;
    longint unsigned      timeout;
    int unsigned          mismatches;
    int unsigned          actions_checked;
    int unsigned          timeouts;
    int unsigned          frames;
    int unsigned          quiet_frames;

    function new();
        period = 64'(PERIOD_RESET);
        timeout = 64'(TIMEOUT_RESET);
        slot = SLOT_CMD;
        idle_ticks = '0;
        foreach (frame_buf[i])
        begin
            frame_buf[i] = '0;
            last_frame[i] = '0;
        end
        mismatches = 0;
        actions_checked = 0;
        timeouts = 0;
        frames = 0;
        quiet_frames = 0;
    endfunction

    function void write_reg(logic [CFG_IDX_W-1:0] index, logic [CFG_W-1:0] value);
        if (index == REG_PWM_PERIOD)
            period = 64'(value);
        else
            timeout = 64'(value[TIMEOUT_W-1:0]);
    endfunction

    function action_t shutoff_action(action_t a);
        a.all_off = 1'b1;
        a.drive_update = 1'b1;
        a.forward_pin = 1'b1;
        a.reverse_pin = 1'b1;
        a.drive_duty = '0;
        a.drive_led = LED_OFF;
        a.steer_update = 1'b1;
        a.steer_duty = DUTY_BITS'(period * STEER_SCALE / ANGLE_CENTRE);
        a.steer_indicator = IND_DARK;
        return a;
    endfunction

    function action_t steer_action(action_t a, logic [BYTE_W-1:0] angle);
        longint unsigned d;
        d = period;
        // angle zero saturates like any quotient above the period
        if (angle != 0)
        begin
            d = period * STEER_SCALE / angle;
            if (d > period)
                d = period;
        end
        a.steer_update = 1'b1;
        a.steer_duty = DUTY_BITS'(d);
        if (angle < ANGLE_CENTRE)
            a.steer_indicator = IND_LEFT;
        else if (angle > ANGLE_CENTRE)
            a.steer_indicator = IND_RIGHT;
        else
            a.steer_indicator = IND_CENTRE;
        return a;
    endfunction

    function action_t drive_action(action_t a, logic [BYTE_W-1:0] cmd,
                                   logic [BYTE_W-1:0] speed);
        logic [DUTY_BITS-1:0] d;
        d = DUTY_BITS'(period * speed / SPEED_FULL);
        a.drive_update = 1'b1;
        if (cmd == CMD_FWD)
        begin
            a.forward_pin = 1'b1;
            a.drive_duty = d;
            a.drive_led = LED_FWD;
        end
        else if (cmd == CMD_REV)
        begin
            a.reverse_pin = 1'b1;
            a.drive_duty = d;
            a.drive_led = LED_REV;
        end
        else
            a.drive_led = LED_BRAKE;
        return a;
    endfunction

    function void note_word(logic op, logic [BYTE_W-1:0] b);
        action_t           a;
        int unsigned       limit;
        int unsigned       next_count;
        logic [SLOT_W-1:0] at;
        a = '0;
        if (op)
        begin
            limit = 32'(timeout);
            if (limit == 0)
                limit = 1;
            next_count = idle_ticks + 1;
            if (next_count < limit)
            begin
                idle_ticks = TIMEOUT_W'(next_count);
                return;
            end
            idle_ticks = '0;
            timeouts++;
            a = shutoff_action(a);
        end
        else
        begin
            at = slot;
            frame_buf[at] = b;
            if (at == SLOT_CMD && (b < CMD_FWD || b > CMD_OFF))
                return;
            if (at != SLOT_LAST)
            begin
                slot = at + 1'b1;
                return;
            end
            slot = SLOT_CMD;
            idle_ticks = '0;
            frames++;
            if (frame_buf[0] != last_frame[0] || frame_buf[1] != last_frame[1])
            begin
                if (frame_buf[0] <= CMD_BRAKE)
                    a = drive_action(a, frame_buf[0], frame_buf[1]);
                else if (frame_buf[0] != CMD_NOP)
                    a = shutoff_action(a);
            end
            // a steering change overrides a shut-off in the same frame; a horn change adds to it
            if (frame_buf[2] != last_frame[2])
                a = steer_action(a, frame_buf[2]);
            if (frame_buf[3] != last_frame[3])
            begin
                a.horn_update = 1'b1;
                a.horn_on = frame_buf[3][HORN_BIT];
            end
            if (a == '0)
                quiet_frames++;
            last_frame = frame_buf;
        end
        expected_actions.push_back(a);
    endfunction

    function void compare_field(string field, logic [63:0] want, logic [63:0] seen);
        if (seen !== want)
        begin
            $error("%s: expected 0x%0h, got 0x%0h", field, want, seen);
            mismatches++;
        end
    endfunction

    function void check_action(action_t got);
        action_t want;
        actions_checked++;
        if (expected_actions.size() == 0)
        begin
            $error("result word with nothing expected: 0x%0h", got);
            mismatches++;
            return;
        end
        want = expected_actions.pop_front();
        compare_field("all_off", want.all_off, got.all_off);
        compare_field("drive_update", want.drive_update, got.drive_update);
        compare_field("forward_pin", want.forward_pin, got.forward_pin);
        compare_field("reverse_pin", want.reverse_pin, got.reverse_pin);
        compare_field("drive_duty", want.drive_duty, got.drive_duty);
        compare_field("drive_led", want.drive_led, got.drive_led);
        compare_field("steer_update", want.steer_update, got.steer_update);
        compare_field("steer_duty", want.steer_duty, got.steer_duty);
        compare_field("steer_indicator", want.steer_indicator, got.steer_indicator);
        compare_field("horn_update", want.horn_update, got.horn_update);
        compare_field("horn_on", want.horn_on, got.horn_on);
    endfunction
endclass

module tb_motor_command_frame_decoder;

    localparam int unsigned PHASES       = 6;
    localparam int unsigned PHASE_WORDS  = 205;
    localparam int unsigned PRESSURE_AT  = 3;
    localparam int unsigned HOLD_CYCLES  = 400;
    localparam int unsigned DRAIN_CYCLES = 100;
    localparam int unsigned QUIET_LIMIT  = 5000;

    logic                 clk;
    logic                 rst_n;
    logic                 cfg_we;
    logic [CFG_IDX_W-1:0] cfg_index;
    logic [CFG_W-1:0]     cfg_data;

    mcfd_in_if  in_ch ();
    mcfd_out_if out_ch ();

    frame_action_scoreboard board;

    bit                hold_request;
    int unsigned       burst_left;
    int unsigned       words_sent;
    int unsigned       quiet_cycles;
    logic [BYTE_W-1:0] last_cmd;
    logic [BYTE_W-1:0] last_speed;
    logic [BYTE_W-1:0] last_angle;
    logic [BYTE_W-1:0] last_acc;

    motor_command_frame_decoder DUT (
        .clk       (clk),
        .rst_n     (rst_n),
        .item      (in_ch),
        .result    (out_ch),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    always
    begin
        clk = 1'b0;
        #1;
        clk = 1'b1;
        #1;
    end

    task automatic send_word(input logic op, input logic [BYTE_W-1:0] b);
        in_ch.valid <= 1'b1;
        in_ch.operation <= op;
        in_ch.rx_byte <= b;
        do
            @(posedge clk);
        while (in_ch.ready !== 1'b1);
        board.note_word(op, b);
        words_sent++;
        if (burst_left > 0)
            burst_left--;
        else
        begin
            in_ch.valid <= 1'b0;
            repeat ($urandom_range(1, 12)) @(posedge clk);
            burst_left = ($urandom_range(0, 7) == 0) ? $urandom_range(60, 250)
                                                     : $urandom_range(0, 12);
        end
    endtask

    task automatic send_tick();
        send_word(1'b1, BYTE_W'($urandom_range(0, 255)));
    endtask

    task automatic send_frame(input logic [BYTE_W-1:0] cmd, input logic [BYTE_W-1:0] speed,
                              input logic [BYTE_W-1:0] angle, input logic [BYTE_W-1:0] acc,
                              input bit with_ticks);
        logic [BYTE_W-1:0] bytes[FRAME_LEN];
        bytes[0] = cmd;
        bytes[1] = speed;
        bytes[2] = angle;
        bytes[3] = acc;
        foreach (bytes[i])
        begin
            // ticks inside a frame must not disturb the partial frame
            if (with_ticks && $urandom_range(0, 9) == 0)
                repeat ($urandom_range(1, 3)) send_tick();
            send_word(1'b0, bytes[i]);
        end
    endtask

    task automatic settle();
        in_ch.valid <= 1'b0;
        burst_left = 0;
        while (board.expected_actions.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
    endtask

    task automatic write_regs(input logic [CFG_W-1:0] period, input logic [CFG_W-1:0] timeout);
        cfg_we <= 1'b1;
        cfg_index <= REG_PWM_PERIOD;
        cfg_data <= period;
        @(posedge clk);
        board.write_reg(REG_PWM_PERIOD, period);
        cfg_index <= REG_FRAME_TIMEOUT;
        cfg_data <= timeout;
        @(posedge clk);
        board.write_reg(REG_FRAME_TIMEOUT, timeout);
        cfg_we <= 1'b0;
    endtask

    task automatic run_directed();
        send_word(1'b0, 8'h00);
        send_word(1'b0, 8'hFF);
        send_frame(CMD_FWD, SPEED_FULL, 8'd0, 8'h20, 1'b0);
        send_frame(CMD_FWD, SPEED_FULL, 8'd0, 8'h20, 1'b0);
        send_frame(CMD_REV, 8'd0, ANGLE_CENTRE, 8'hDF, 1'b0);
        send_frame(CMD_BRAKE, 8'd0, 8'd255, 8'hDF, 1'b0);
        send_frame(CMD_NOP, 8'd7, 8'd149, 8'hDF, 1'b0);
        // shut-off with angle and horn changes in the same frame
        send_frame(CMD_OFF, 8'd7, 8'd1, 8'h20, 1'b0);
        send_tick();
    endtask

    task automatic run_random(input int unsigned n);
        int unsigned       stop_at;
        int unsigned       pick;
        int unsigned       k;
        logic [BYTE_W-1:0] cmd;
        logic [BYTE_W-1:0] speed;
        logic [BYTE_W-1:0] angle;
        logic [BYTE_W-1:0] acc;
        stop_at = words_sent + n;
        while (words_sent < stop_at)
        begin
            pick = $urandom_range(0, 99);
            if (pick < 70)
            begin
                cmd = ($urandom_range(0, 3) == 0) ? last_cmd
                                                  : BYTE_W'(CMD_FWD + $urandom_range(0, 4));
                k = $urandom_range(0, 9);
                speed = (k < 3) ? last_speed : (k == 3) ? 8'd0 : (k == 4) ? SPEED_FULL
                      : BYTE_W'($urandom_range(0, 255));
                k = $urandom_range(0, 11);
                angle = (k < 3) ? last_angle : (k == 3) ? 8'd0 : (k == 4) ? ANGLE_CENTRE
                      : (k == 5) ? 8'd255 : (k == 6) ? 8'd1 : BYTE_W'($urandom_range(0, 255));
                acc = ($urandom_range(0, 9) < 3) ? last_acc : BYTE_W'($urandom_range(0, 255));
                send_frame(cmd, speed, angle, acc, 1'b1);
                last_cmd = cmd;
                last_speed = speed;
                last_angle = angle;
                last_acc = acc;
            end
            else if (pick < 82)
                repeat ($urandom_range(1, 12)) send_tick();
            else if (pick < 92)
                send_word(1'b0, BYTE_W'($urandom_range(0, 255)));
            else
            begin
                // truncated frame: the decoder must resync on what follows
                send_word(1'b0, BYTE_W'(CMD_FWD + $urandom_range(0, 4)));
                repeat ($urandom_range(1, 2)) send_word(1'b0, BYTE_W'($urandom_range(0, 255)));
            end
        end
    endtask

    // result side: check accepted words, stall on a drifting pattern
    initial
    begin : result_sink
        int unsigned cyc;
        int unsigned hold_left;
        int unsigned mode;
        bit          take;
        bit          hold_done;
        cyc = 0;
        hold_left = 0;
        mode = 0;
        hold_done = 1'b0;
        out_ch.ready <= 1'b0;
        wait (rst_n === 1'b1);
        forever
        begin
            @(posedge clk);
            if (out_ch.valid === 1'b1 && out_ch.ready === 1'b1)
                board.check_action({out_ch.all_off, out_ch.drive_update, out_ch.forward_pin,
                                    out_ch.reverse_pin, out_ch.drive_duty, out_ch.drive_led,
                                    out_ch.steer_update, out_ch.steer_duty,
                                    out_ch.steer_indicator, out_ch.horn_update,
                                    out_ch.horn_on});
            cyc++;
            if (cyc % 50 == 0)
                mode = $urandom_range(0, 3);
            if (hold_request && !hold_done)
            begin
                hold_left = HOLD_CYCLES;
                hold_done = 1'b1;
            end
            case (mode)
                0: take = 1'b1;
                1: take = ($urandom_range(0, 2) != 0);
                2: take = ((cyc % 6) < 4);
                default: take = ($urandom_range(0, 5) == 0);
            endcase
            if (hold_left > 0)
            begin
                hold_left--;
                take = 1'b0;
            end
            out_ch.ready <= take;
        end
    end

    // watchdog: nothing moved on either channel for too long
    always @(posedge clk)
    begin
        if (rst_n !== 1'b1 || (in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready))
            quiet_cycles <= 0;
        else if (quiet_cycles == QUIET_LIMIT)
        begin
            $error("no word moved for %0d cycles", QUIET_LIMIT);
            $display("== FAIL ==");
            $finish;
        end
        else
            quiet_cycles <= quiet_cycles + 1;
    end

    initial
    begin : stimulus
        logic [CFG_W-1:0] periods[PHASES];
        logic [CFG_W-1:0] timeouts[PHASES];
        board = new();
        hold_request = 1'b0;
        burst_left = 0;
        words_sent = 0;
        last_cmd = CMD_FWD;
        last_speed = '0;
        last_angle = '0;
        last_acc = '0;
        rst_n <= 1'b0;
        cfg_we <= 1'b0;
        cfg_index <= REG_PWM_PERIOD;
        cfg_data <= '0;
        in_ch.valid <= 1'b0;
        in_ch.operation <= 1'b0;
        in_ch.rx_byte <= '0;

        periods = '{24'hFFFFFF, 24'd1, 24'd0, PERIOD_RESET,
                    CFG_W'($urandom_range(2, 24'hFFFFFE)), 24'd255};
        timeouts = '{24'd1, 24'd65535, 24'd0, 24'd7, CFG_W'($urandom_range(2, 40)), 24'd3};

        repeat (8) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        run_directed();
        for (int unsigned p = 0; p < PHASES; p++)
        begin
            settle();
            write_regs(periods[p], timeouts[p]);
            if (p == PRESSURE_AT)
                hold_request = 1'b1;
            run_random(PHASE_WORDS);
        end
        settle();

        if (board.expected_actions.size() != 0)
            $error("%0d expected result words never arrived", board.expected_actions.size());
        $display("Run covered %0d words: %0d frames (%0d with no change), %0d timeouts.",
                 words_sent, board.frames, board.quiet_frames, board.timeouts);
        $display("%0d result words checked over %0d register settings, one long output hold.",
                 board.actions_checked, PHASES + 1);
        if (board.mismatches == 0 && board.expected_actions.size() == 0)
            $display("== PASS ==");
        else
            $display("== FAIL ==");
        $finish;
    end

endmodule
